### rtl/pinhole_radtan_projection_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for pinhole_radtan_projection_top
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_RADTAN_PROJECTION_TOP_MACROS_SVH
`define PINHOLE_RADTAN_PROJECTION_TOP_MACROS_SVH

`define PRP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define PRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`define PRP_ASSERT_DELAY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

### rtl/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg
// Shared types, register indexes and fixed-point helpers for the projection.
// ----------------------------------------------------------------------------
package prp_pkg;

	localparam int DIV_BITS = 32;
	localparam int LATENCY  = 47;

	localparam logic signed [31:0] Q28_ONE = 32'sd268435456;

	typedef enum logic [3:0] {
		REG_FOCAL_X    = 4'd0,
		REG_FOCAL_Y    = 4'd1,
		REG_CENTER_X   = 4'd2,
		REG_CENTER_Y   = 4'd3,
		REG_RADIAL_K1  = 4'd4,
		REG_RADIAL_K2  = 4'd5,
		REG_TANGENT_P1 = 4'd6,
		REG_TANGENT_P2 = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic ovf;
		logic signed [31:0] val;
	} qres_t;

	typedef struct packed {
		logic vld;
		logic ok;
		logic sat;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} div_out_t;

	function automatic qres_t sat40(input logic signed [39:0] v);
		qres_t r;
		if (v > 40'sd2147483647) begin
			r.ovf = 1'b1;
			r.val = 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			r.ovf = 1'b1;
			r.val = 32'sh80000000;
		end else begin
			r.ovf = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

	function automatic qres_t qround(input logic signed [63:0] p);
		logic signed [64:0] t;
		t = $signed({p[63], p}) + 65'sd134217728;
		return sat40($signed({{3{t[64]}}, t[64:28]}));
	endfunction

	function automatic qres_t qadd(input logic signed [31:0] a, input logic signed [31:0] b);
		return sat40($signed({{8{a[31]}}, a}) + $signed({{8{b[31]}}, b}));
	endfunction

	function automatic qres_t to_pixel(input logic signed [64:0] p,
			input logic signed [31:0] c);
		logic signed [65:0] t;
		t = $signed({p[64], p}) + 66'sd134217728;
		return sat40($signed({{2{t[65]}}, t[65:28]}) + $signed({{8{c[31]}}, c}));
	endfunction

endpackage

### rtl/prp_div.sv
// ----------------------------------------------------------------------------
// prp_div
// Pipelined restoring divider giving x = X*2^28/Z and y = Y*2^28/Z in Q4.28,
// truncated toward zero and saturated, one quotient bit per stage.
// ----------------------------------------------------------------------------
module prp_div import prp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [31:0] num_x,
	input  logic signed [31:0] num_y,
	input  logic signed [31:0] den,
	output div_out_t           result
);

	logic        vld_q  [0:DIV_BITS];
	logic        ok_q   [0:DIV_BITS];
	logic        negx_q [0:DIV_BITS];
	logic        negy_q [0:DIV_BITS];
	logic        ovfx_q [0:DIV_BITS];
	logic        ovfy_q [0:DIV_BITS];
	logic [30:0] z_q    [0:DIV_BITS];
	logic [3:0]  axlo_q [0:DIV_BITS];
	logic [3:0]  aylo_q [0:DIV_BITS];
	logic [30:0] remx_q [0:DIV_BITS];
	logic [30:0] remy_q [0:DIV_BITS];
	logic [31:0] qx_q   [0:DIV_BITS];
	logic [31:0] qy_q   [0:DIV_BITS];

	logic [30:0] remx_nxt [0:DIV_BITS-1];
	logic [30:0] remy_nxt [0:DIV_BITS-1];
	logic        gex      [0:DIV_BITS-1];
	logic        gey      [0:DIV_BITS-1];

	logic [31:0] ax, ay;
	logic [30:0] zin;

	logic               vld_out_q, ok_out_q, sat_out_q;
	logic signed [31:0] x_out_q, y_out_q;

	assign ax  = num_x[31] ? 32'(-num_x) : 32'(num_x);
	assign ay  = num_y[31] ? 32'(-num_y) : 32'(num_y);
	assign zin = den[30:0];

	assign result = '{vld: vld_out_q, ok: ok_out_q, sat: sat_out_q, x: x_out_q, y: y_out_q};

	always_comb begin
		logic [31:0] shx, shy;
		logic        bx, by;
		for (int k = 0; k < DIV_BITS; k++) begin
			bx = (k < 4) ? axlo_q[k][2'(3 - k)] : 1'b0;
			by = (k < 4) ? aylo_q[k][2'(3 - k)] : 1'b0;
			shx = {remx_q[k], bx};
			shy = {remy_q[k], by};
			gex[k] = shx >= {1'b0, z_q[k]};
			gey[k] = shy >= {1'b0, z_q[k]};
			remx_nxt[k] = gex[k] ? 31'(shx - {1'b0, z_q[k]}) : shx[30:0];
			remy_nxt[k] = gey[k] ? 31'(shy - {1'b0, z_q[k]}) : shy[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_BITS; k++) vld_q[k] <= 1'b0;
			vld_out_q <= 1'b0;
		end else begin
			vld_q[0] <= in_valid;
			for (int k = 0; k < DIV_BITS; k++) vld_q[k+1] <= vld_q[k];
			vld_out_q <= vld_q[DIV_BITS];
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] mx, my;
		ok_q[0]   <= !den[31] && (den != 32'sd0);
		negx_q[0] <= num_x[31];
		negy_q[0] <= num_y[31];
		ovfx_q[0] <= {4'b0, ax} >= {1'b0, zin, 4'b0};
		ovfy_q[0] <= {4'b0, ay} >= {1'b0, zin, 4'b0};
		z_q[0]    <= zin;
		axlo_q[0] <= ax[3:0];
		aylo_q[0] <= ay[3:0];
		remx_q[0] <= {3'b0, ax[31:4]};
		remy_q[0] <= {3'b0, ay[31:4]};
		qx_q[0]   <= '0;
		qy_q[0]   <= '0;
		for (int k = 0; k < DIV_BITS; k++) begin
			ok_q[k+1]   <= ok_q[k];
			negx_q[k+1] <= negx_q[k];
			negy_q[k+1] <= negy_q[k];
			ovfx_q[k+1] <= ovfx_q[k];
			ovfy_q[k+1] <= ovfy_q[k];
			z_q[k+1]    <= z_q[k];
			axlo_q[k+1] <= axlo_q[k];
			aylo_q[k+1] <= aylo_q[k];
			remx_q[k+1] <= remx_nxt[k];
			remy_q[k+1] <= remy_nxt[k];
			qx_q[k+1]   <= {qx_q[k][30:0], gex[k]};
			qy_q[k+1]   <= {qy_q[k][30:0], gey[k]};
		end
		mx = qx_q[DIV_BITS];
		my = qy_q[DIV_BITS];
		ok_out_q  <= ok_q[DIV_BITS];
		sat_out_q <= ovfx_q[DIV_BITS] || ovfy_q[DIV_BITS]
			|| (negx_q[DIV_BITS] ? (mx > 32'h80000000) : mx[31])
			|| (negy_q[DIV_BITS] ? (my > 32'h80000000) : my[31]);
		if (negx_q[DIV_BITS]) begin
			x_out_q <= (ovfx_q[DIV_BITS] || mx > 32'h80000000) ? 32'sh80000000 : $signed(-mx);
		end else begin
			x_out_q <= (ovfx_q[DIV_BITS] || mx[31]) ? 32'sh7fffffff : $signed(mx);
		end
		if (negy_q[DIV_BITS]) begin
			y_out_q <= (ovfy_q[DIV_BITS] || my > 32'h80000000) ? 32'sh80000000 : $signed(-my);
		end else begin
			y_out_q <= (ovfy_q[DIV_BITS] || my[31]) ? 32'sh7fffffff : $signed(my);
		end
	end

endmodule

### rtl/pinhole_radtan_projection_top.sv
// ----------------------------------------------------------------------------
// pinhole_radtan_projection_top
// Pinhole projection of a camera-frame point with radial and tangential
// lens distortion, fully pipelined.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// point     in         start, busy          point_x, point_y, point_z
// pixel     out        done (strobe)        pixel_u, pixel_v, valid_res, saturated
// config    in         cfg_valid, cfg_ready cfg_index, cfg_data
//
// A point is taken every cycle; its pixel passes through the divider's 32
// quotient stages and then the chain of five multiply levels before done.
// busy is always low and cfg_ready is always high.
// Reset clears the stage valid bits and loads the default registers.
// The receiver cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
module pinhole_radtan_projection_top import prp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               done,
	output logic signed [31:0] pixel_u,
	output logic signed [31:0] pixel_v,
	output logic               valid_res,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

`include "pinhole_radtan_projection_top_macros.svh"

	logic [31:0]        focal_x_q, focal_y_q;
	logic signed [31:0] center_x_q, center_y_q, k1_q, k2_q, p1_q, p2_q;
	div_out_t           dv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6, ok_s7, ok_s8, ok_s9, ok_s10;
	logic ok_s11, ok_s12;
	logic sat_s1, sat_s2, sat_s3, sat_s4, sat_s5, sat_s6, sat_s7, sat_s8, sat_s9;
	logic sat_s10, sat_s11, sat_s12;
	logic signed [31:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8;
	logic signed [31:0] y_s1, y_s2, y_s3, y_s4, y_s5, y_s6, y_s7, y_s8;
	logic signed [63:0] pxx_s1, pyy_s1, pxy_s1;
	logic signed [31:0] xx_s2, yy_s2, xy_s2;
	logic signed [31:0] r2_s3, dxx_s3, dyy_s3, xy_s3;
	logic signed [63:0] pr4_s4, pk1_s4, pa_s4, pb_s4;
	logic signed [31:0] sx_s4, sy_s4;
	logic signed [31:0] r4_s5, k1r2_s5, a_s5, b_s5, sx_s5, sy_s5;
	logic signed [63:0] pk2_s6, ptx_s6, pty_s6;
	logic signed [31:0] rad1_s6, da_s6, db_s6;
	logic signed [31:0] k2r4_s7, p2sx_s7, p1sy_s7, rad1_s7, da_s7, db_s7;
	logic signed [31:0] rad_s8, tx_s8, ty_s8;
	logic signed [63:0] pxr_s9, pyr_s9;
	logic signed [31:0] tx_s9, ty_s9;
	logic signed [31:0] xr_s10, yr_s10, tx_s10, ty_s10;
	logic signed [31:0] xd_s11, yd_s11;
	logic signed [64:0] pu_s12, pv_s12;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= 32'd65536;
			focal_y_q  <= 32'd65536;
			center_x_q <= '0;
			center_y_q <= '0;
			k1_q       <= '0;
			k2_q       <= '0;
			p1_q       <= '0;
			p2_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FOCAL_X:    focal_x_q  <= cfg_data;
				REG_FOCAL_Y:    focal_y_q  <= cfg_data;
				REG_CENTER_X:   center_x_q <= $signed(cfg_data);
				REG_CENTER_Y:   center_y_q <= $signed(cfg_data);
				REG_RADIAL_K1:  k1_q       <= $signed(cfg_data);
				REG_RADIAL_K2:  k2_q       <= $signed(cfg_data);
				REG_TANGENT_P1: p1_q       <= $signed(cfg_data);
				REG_TANGENT_P2: p2_q       <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	prp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.num_x    (point_x),
		.num_y    (point_y),
		.den      (point_z),
		.result   (dv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0; vld_s11 <= 1'b0; vld_s12 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1  <= dv.vld;  vld_s2  <= vld_s1;  vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;  vld_s5  <= vld_s4;  vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;  vld_s8  <= vld_s7;  vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;  vld_s11 <= vld_s10; vld_s12 <= vld_s11;
			done    <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		qres_t xx, yy, xy, r2, dxx, dyy, sx, sy, r4, k1r2, a, b, rad1, da, db;
		qres_t k2r4, p2sx, p1sy, rad, tx, ty, xr, yr, xd, yd, u, v;

		ok_s1  <= dv.ok;
		sat_s1 <= dv.sat;
		x_s1   <= dv.x;
		y_s1   <= dv.y;
		pxx_s1 <= dv.x * dv.x;
		pyy_s1 <= dv.y * dv.y;
		pxy_s1 <= dv.x * dv.y;

		xx = qround(pxx_s1);
		yy = qround(pyy_s1);
		xy = qround(pxy_s1);
		ok_s2  <= ok_s1;
		sat_s2 <= sat_s1 || xx.ovf || yy.ovf || xy.ovf;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		xx_s2  <= xx.val;
		yy_s2  <= yy.val;
		xy_s2  <= xy.val;

		r2  = qadd(xx_s2, yy_s2);
		dxx = qadd(xx_s2, xx_s2);
		dyy = qadd(yy_s2, yy_s2);
		ok_s3  <= ok_s2;
		sat_s3 <= sat_s2 || r2.ovf || dxx.ovf || dyy.ovf;
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		r2_s3  <= r2.val;
		dxx_s3 <= dxx.val;
		dyy_s3 <= dyy.val;
		xy_s3  <= xy_s2;

		sx = qadd(r2_s3, dxx_s3);
		sy = qadd(r2_s3, dyy_s3);
		ok_s4  <= ok_s3;
		sat_s4 <= sat_s3 || sx.ovf || sy.ovf;
		x_s4   <= x_s3;
		y_s4   <= y_s3;
		pr4_s4 <= r2_s3 * r2_s3;
		pk1_s4 <= k1_q * r2_s3;
		pa_s4  <= p1_q * xy_s3;
		pb_s4  <= p2_q * xy_s3;
		sx_s4  <= sx.val;
		sy_s4  <= sy.val;

		r4   = qround(pr4_s4);
		k1r2 = qround(pk1_s4);
		a    = qround(pa_s4);
		b    = qround(pb_s4);
		ok_s5   <= ok_s4;
		sat_s5  <= sat_s4 || r4.ovf || k1r2.ovf || a.ovf || b.ovf;
		x_s5    <= x_s4;
		y_s5    <= y_s4;
		r4_s5   <= r4.val;
		k1r2_s5 <= k1r2.val;
		a_s5    <= a.val;
		b_s5    <= b.val;
		sx_s5   <= sx_s4;
		sy_s5   <= sy_s4;

		rad1 = qadd(Q28_ONE, k1r2_s5);
		da   = qadd(a_s5, a_s5);
		db   = qadd(b_s5, b_s5);
		ok_s6   <= ok_s5;
		sat_s6  <= sat_s5 || rad1.ovf || da.ovf || db.ovf;
		x_s6    <= x_s5;
		y_s6    <= y_s5;
		pk2_s6  <= k2_q * r4_s5;
		ptx_s6  <= p2_q * sx_s5;
		pty_s6  <= p1_q * sy_s5;
		rad1_s6 <= rad1.val;
		da_s6   <= da.val;
		db_s6   <= db.val;

		k2r4 = qround(pk2_s6);
		p2sx = qround(ptx_s6);
		p1sy = qround(pty_s6);
		ok_s7   <= ok_s6;
		sat_s7  <= sat_s6 || k2r4.ovf || p2sx.ovf || p1sy.ovf;
		x_s7    <= x_s6;
		y_s7    <= y_s6;
		k2r4_s7 <= k2r4.val;
		p2sx_s7 <= p2sx.val;
		p1sy_s7 <= p1sy.val;
		rad1_s7 <= rad1_s6;
		da_s7   <= da_s6;
		db_s7   <= db_s6;

		rad = qadd(rad1_s7, k2r4_s7);
		tx  = qadd(da_s7, p2sx_s7);
		ty  = qadd(p1sy_s7, db_s7);
		ok_s8  <= ok_s7;
		sat_s8 <= sat_s7 || rad.ovf || tx.ovf || ty.ovf;
		x_s8   <= x_s7;
		y_s8   <= y_s7;
		rad_s8 <= rad.val;
		tx_s8  <= tx.val;
		ty_s8  <= ty.val;

		ok_s9  <= ok_s8;
		sat_s9 <= sat_s8;
		pxr_s9 <= x_s8 * rad_s8;
		pyr_s9 <= y_s8 * rad_s8;
		tx_s9  <= tx_s8;
		ty_s9  <= ty_s8;

		xr = qround(pxr_s9);
		yr = qround(pyr_s9);
		ok_s10  <= ok_s9;
		sat_s10 <= sat_s9 || xr.ovf || yr.ovf;
		xr_s10  <= xr.val;
		yr_s10  <= yr.val;
		tx_s10  <= tx_s9;
		ty_s10  <= ty_s9;

		xd = qadd(xr_s10, tx_s10);
		yd = qadd(yr_s10, ty_s10);
		ok_s11  <= ok_s10;
		sat_s11 <= sat_s10 || xd.ovf || yd.ovf;
		xd_s11  <= xd.val;
		yd_s11  <= yd.val;

		ok_s12  <= ok_s11;
		sat_s12 <= sat_s11;
		pu_s12  <= $signed({1'b0, focal_x_q}) * xd_s11;
		pv_s12  <= $signed({1'b0, focal_y_q}) * yd_s11;

		u = to_pixel(pu_s12, center_x_q);
		v = to_pixel(pv_s12, center_y_q);
		valid_res <= ok_s12;
		saturated <= ok_s12 && (sat_s12 || u.ovf || v.ovf);
		pixel_u   <= ok_s12 ? u.val : 32'sd0;
		pixel_v   <= ok_s12 ? v.val : 32'sd0;
	end

	`PRP_ASSERT_IMPL(a_behind_zero, done && !valid_res,
		pixel_u == 32'sd0 && pixel_v == 32'sd0 && !saturated,
		"Point behind the camera gave a nonzero result.")
	`PRP_ASSERT_DELAY(a_latency, start && !busy, 47, done,
		"Accepted point produced no result after the pipeline latency.")
	`PRP_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, LATENCY),
		"Result strobe without a matching point transfer.")
	`PRP_ASSERT_NEXT(a_cfg_fx, cfg_valid && cfg_ready && cfg_index == REG_FOCAL_X,
		focal_x_q == $past(cfg_data),
		"Focal length write was not captured.")

endmodule

### tb/pinhole_radtan_projection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_radtan_projection_checker
// Watches the point, pixel and configuration channels of the projection,
// predicts each pixel in fixed point from the accepted point and the current
// registers, and compares every field of each pixel with the oldest
// prediction.
// ----------------------------------------------------------------------------
module pinhole_radtan_projection_checker import prp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic               done,
	input  logic signed [31:0] pixel_u,
	input  logic signed [31:0] pixel_v,
	input  logic               valid_res,
	input  logic               saturated,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 pixels_seen,
	output int                 saturated_seen
);

	typedef struct {
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic               vis;
		logic               sat;
	} pixel_t;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam longint ONE_Q28 = 64'sd268435456;
	localparam longint HALF_Q28 = 64'sd134217728;

	logic [31:0] fx, fy;
	logic signed [31:0] cx, cy, k1, k2, p1, p2;
	pixel_t expected_pixels[$];
	bit clamp_hit;

	function automatic longint clamp(longint v);
		if (v > S32_MAX) begin
			clamp_hit = 1'b1;
			return S32_MAX;
		end
		if (v < S32_MIN) begin
			clamp_hit = 1'b1;
			return S32_MIN;
		end
		return v;
	endfunction

	function automatic longint mul_q28(longint a, longint b);
		return clamp((a * b + HALF_Q28) >>> 28);
	endfunction

	function automatic longint add_q28(longint a, longint b);
		return clamp(a + b);
	endfunction

	function automatic longint scale_pixel(logic [31:0] f, longint d, logic signed [31:0] c);
		longint prod;
		prod = longint'({32'd0, f}) * d;
		return clamp(((prod + HALF_Q28) >>> 28) + longint'(c));
	endfunction

	function automatic pixel_t project(longint px, longint py, longint pz);
		pixel_t r;
		longint x, y, xx, yy, xy, r2, r4, rad, a, b, sx, sy, tx, ty, xd, yd;
		clamp_hit = 1'b0;
		r = '{u: 0, v: 0, vis: 1'b0, sat: 1'b0};
		if (pz <= 0) return r;
		x = clamp((px * ONE_Q28) / pz);
		y = clamp((py * ONE_Q28) / pz);
		xx = mul_q28(x, x);
		yy = mul_q28(y, y);
		xy = mul_q28(x, y);
		r2 = add_q28(xx, yy);
		r4 = mul_q28(r2, r2);
		rad = add_q28(ONE_Q28, mul_q28(k1, r2));
		rad = add_q28(rad, mul_q28(k2, r4));
		a = mul_q28(p1, xy);
		b = mul_q28(p2, xy);
		sx = add_q28(r2, add_q28(xx, xx));
		sy = add_q28(r2, add_q28(yy, yy));
		tx = add_q28(add_q28(a, a), mul_q28(p2, sx));
		ty = add_q28(mul_q28(p1, sy), add_q28(b, b));
		xd = add_q28(mul_q28(x, rad), tx);
		yd = add_q28(mul_q28(y, rad), ty);
		r.u = 32'(scale_pixel(fx, xd, cx));
		r.v = 32'(scale_pixel(fy, yd, cy));
		r.vis = 1'b1;
		r.sat = clamp_hit;
		return r;
	endfunction

	assign pending = expected_pixels.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			fx <= 32'd65536;
			fy <= 32'd65536;
			cx <= '0;
			cy <= '0;
			k1 <= '0;
			k2 <= '0;
			p1 <= '0;
			p2 <= '0;
			errors <= 0;
			pixels_seen <= 0;
			saturated_seen <= 0;
			expected_pixels.delete();
		end else begin
			if (done) begin
				pixels_seen <= pixels_seen + 1;
				if (saturated) saturated_seen <= saturated_seen + 1;
				if (expected_pixels.size() == 0) begin
					$display("%0t: pixel with none expected: u=%h v=%h", $time, pixel_u,
						pixel_v);
					errors <= errors + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (want.u !== pixel_u || want.v !== pixel_v || want.vis !== valid_res
							|| want.sat !== saturated) begin
						$display("%0t: mismatch expected u=%h v=%h valid=%b sat=%b", $time,
							want.u, want.v, want.vis, want.sat);
						$display("%0t:          actual   u=%h v=%h valid=%b sat=%b", $time,
							pixel_u, pixel_v, valid_res, saturated);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				expected_pixels.push_back(project(point_x, point_y, point_z));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FOCAL_X:    fx <= cfg_data;
					REG_FOCAL_Y:    fy <= cfg_data;
					REG_CENTER_X:   cx <= cfg_data;
					REG_CENTER_Y:   cy <= cfg_data;
					REG_RADIAL_K1:  k1 <= cfg_data;
					REG_RADIAL_K2:  k2 <= cfg_data;
					REG_TANGENT_P1: p1 <= cfg_data;
					REG_TANGENT_P2: p2 <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

### tb/pinhole_radtan_projection_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_radtan_projection_top_tb
// Drives camera-frame points through the projection under several register
// settings, from the reset values to the extremes, with random gaps between
// transfers in all phases but one, where points go back to back; the checker
// predicts and compares every pixel.
module pinhole_radtan_projection_top_tb import prp_pkg::*; ();

	localparam logic [3:0] REG_UNUSED = 4'd12;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASES = 7;
	localparam int POINTS_PER_PHASE = 135;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic cfg_valid = 1'b0;
	logic [3:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic busy, done, valid_res, saturated, cfg_ready;
	logic signed [31:0] pixel_u, pixel_v;
	int errors, pending, pixels_seen, saturated_seen;
	int stall_cycles = 0;
	bit gaps_on = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pinhole_radtan_projection_top uut (.*);

	pinhole_radtan_projection_checker checker_i (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout at %0t with %0d pixels outstanding", $time, pending);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_point(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz);
		while (gaps_on && $urandom_range(0, 99) < 14) begin
			@(negedge clk);
			start = 1'b0;
			cfg_valid = 1'b0;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
		start = 1'b1;
		point_x = px;
		point_y = py;
		point_z = pz;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
		while ($urandom_range(0, 99) < 14) begin
			@(negedge clk);
			start = 1'b0;
			cfg_valid = 1'b0;
		end
		@(negedge clk);
		start = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		cfg_valid = 1'b0;
		wait (pending == 0);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic logic [31:0] spread(int range);
		return 32'($signed($urandom_range(0, 2 * range)) - range);
	endfunction

	task automatic random_point();
		int kind, depth;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			send_point($urandom, $urandom, $urandom);
		end else if (kind == 1) begin
			send_point($urandom, $urandom, -$signed($urandom_range(0, 32'h7fffffff)));
		end else begin
			depth = $urandom_range(32'h0000_1000, 32'h0100_0000);
			send_point(spread(depth), spread(depth), depth);
		end
	endtask

	task automatic set_camera(input logic [31:0] fxv, input logic [31:0] fyv,
			input logic [31:0] cxv, input logic [31:0] cyv, input logic [31:0] k1v,
			input logic [31:0] k2v, input logic [31:0] p1v, input logic [31:0] p2v);
		write_reg(REG_FOCAL_X, fxv);
		write_reg(REG_FOCAL_Y, fyv);
		write_reg(REG_CENTER_X, cxv);
		write_reg(REG_CENTER_Y, cyv);
		write_reg(REG_RADIAL_K1, k1v);
		write_reg(REG_RADIAL_K2, k2v);
		write_reg(REG_TANGENT_P1, p1v);
		write_reg(REG_TANGENT_P2, p2v);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed points under the reset registers: depth sign, range extremes.
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
		send_point('0, '0, 32'h0000_0001);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'h0001_0000, 32'h0001_0000, '0);
		send_point(32'h0001_0000, 32'h0001_0000, 32'hffff_ffff);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_point(32'h0007_0000, 32'hfff9_0000, 32'h0001_0000);
		send_point(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
		drain();

		set_camera(32'd500 << 16, 32'd480 << 16, 32'd320 << 16, 32'd240 << 16,
			-32'sd26843546, 32'sd5368709, 32'sd268435, -32'sd134217);
		write_reg(REG_UNUSED, 32'hdead_beef);
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_point(32'hffff_0000, 32'h0000_8000, 32'h0002_0000);
		send_point(32'h0003_0000, 32'hfffd_0000, 32'h0001_0000);
		send_point(32'h7fff_ffff, 32'h0000_0000, 32'h0000_0100);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_camera(32'd65536, 32'd65536, '0, '0, '0, '0, '0, '0);
				1: set_camera('1, '1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
					32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
				2: set_camera('0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
				default: set_camera($urandom_range(32'd50 << 16, 32'd4000 << 16),
					$urandom_range(32'd50 << 16, 32'd4000 << 16), spread(32'h0400_0000),
					spread(32'h0400_0000), spread(32'h0800_0000), spread(32'h0200_0000),
					spread(32'h0040_0000), spread(32'h0040_0000));
			endcase
			gaps_on = (ph != 4);
			repeat (POINTS_PER_PHASE) random_point();
			drain();
		end

		$display("Projected %0d points over %0d register settings, %0d with clamping.",
			pixels_seen, PHASES + 2, saturated_seen);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
